/* sv/bpm_pkg.sv */
// ----------------------------------------------------------------------------
// Bracket pair matcher package
// Sizes, result kinds and the record passed between the control stage and the
// output stage of the bracket pair matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Table and stack bounds, and the width of a character position.
  localparam int unsigned MAX_ENTRIES = 32768;
  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned POS_WIDTH   = 16;

  // Derived widths.
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned TOP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned POS_W  = POS_WIDTH + 1;

  // Characters that act on the stack.
  localparam logic [7:0] SYM_OPEN  = 8'h5B;
  localparam logic [7:0] SYM_CLOSE = 8'h5D;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_ENTRY      = 3'd0,
    KIND_SUMMARY    = 3'd1,
    KIND_UNMATCHED  = 3'd2,
    KIND_TABLE_FULL = 3'd3,
    KIND_STACK_OVF  = 3'd4,
    KIND_TOO_LONG   = 3'd5
  } kind_e;

  // One pending result: its kind, the character position and the entry count
  // at the time the character was taken.
  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt;
  } desc_t;

  // Stack memory request issued by the control stage.
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [POS_WIDTH-1:0]  wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;

endpackage

/* sv/bpm_if.sv */
// ----------------------------------------------------------------------------
// Bracket pair matcher channels
// Valid/ready channels for program characters and for jump table results.
// ----------------------------------------------------------------------------
interface bpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_program;

  modport source(output valid, symbol, end_of_program, input ready);
  modport sink(input valid, symbol, end_of_program, output ready);
endinterface

interface bpm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] from_pos;
  logic [15:0] to_pos;
  logic [14:0] entry_index;
  logic [15:0] entry_total;
  logic        last;

  modport source(output valid, kind, from_pos, to_pos, entry_index, entry_total, last,
                 input ready);
  modport sink(input valid, kind, from_pos, to_pos, entry_index, entry_total, last,
               output ready);
endinterface

/* sv/bpm_ram.sv */
// ----------------------------------------------------------------------------
// Bracket pair matcher stack RAM
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that updates only when a read is issued.
// ----------------------------------------------------------------------------
module bpm_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/bpm_ctrl.sv */
// ----------------------------------------------------------------------------
// Bracket pair matcher control stage
// Takes one character per cycle unless stalled, keeps stack pointer, position,
// entry count and sticky error, drives stack RAM, queues one result record.
// ----------------------------------------------------------------------------
module bpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  bpm_in_if.sink              in_i,
  output logic                s1_valid_o,
  output bpm_pkg::desc_t      s1_desc_o,
  input  logic                s1_take_i,
  output bpm_pkg::ram_req_t   ram_req_o
);

  logic                          acc;
  logic [bpm_pkg::TOP_W-1:0]     top_q, top_d;
  logic [bpm_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [bpm_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          err_q, err_d;
  logic                          s1_valid_q, s1_valid_d;
  bpm_pkg::desc_t                s1_desc_q, s1_desc_d;
  logic [bpm_pkg::CNT_W:0]       cnt_plus2;

  // A new character is taken whenever the result slot is free or drains now.
  assign in_i.ready = !s1_valid_q || s1_take_i;
  assign acc        = in_i.valid && in_i.ready;
  assign cnt_plus2  = {1'b0, cnt_q} + (bpm_pkg::CNT_W + 1)'(2);

  // Character handling: every state update happens in the transfer cycle.
  always_comb begin
    top_d      = top_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    err_d      = err_q;
    s1_valid_d = s1_valid_q && !s1_take_i;
    s1_desc_d  = s1_desc_q;
    ram_req_o  = '0;

    if (acc) begin
      if (in_i.end_of_program) begin
        // Summary with the final count, then back to the reset state.
        s1_valid_d     = 1'b1;
        s1_desc_d.kind = bpm_pkg::KIND_SUMMARY;
        s1_desc_d.pos  = '0;
        s1_desc_d.cnt  = cnt_q;
        top_d          = '0;
        pos_d          = '0;
        cnt_d          = '0;
        err_d          = 1'b0;
      end else if (!err_q) begin
        // The position counter stops one past the largest position.
        if (!pos_q[bpm_pkg::POS_WIDTH]) begin
          pos_d = pos_q + bpm_pkg::POS_W'(1);
        end
        s1_desc_d.pos = pos_q;
        s1_desc_d.cnt = cnt_q;

        if (pos_q[bpm_pkg::POS_WIDTH]) begin
          err_d          = 1'b1;
          s1_valid_d     = 1'b1;
          s1_desc_d.kind = bpm_pkg::KIND_TOO_LONG;
        end else if (in_i.symbol == bpm_pkg::SYM_OPEN) begin
          if (top_q == bpm_pkg::TOP_W'(bpm_pkg::STACK_DEPTH)) begin
            err_d          = 1'b1;
            s1_valid_d     = 1'b1;
            s1_desc_d.kind = bpm_pkg::KIND_STACK_OVF;
          end else begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = top_q[bpm_pkg::ADDR_W-1:0];
            ram_req_o.wdata = pos_q[bpm_pkg::POS_WIDTH-1:0];
            top_d           = top_q + bpm_pkg::TOP_W'(1);
          end
        end else if (in_i.symbol == bpm_pkg::SYM_CLOSE) begin
          if (top_q == '0) begin
            err_d          = 1'b1;
            s1_valid_d     = 1'b1;
            s1_desc_d.kind = bpm_pkg::KIND_UNMATCHED;
          end else if (cnt_plus2 > (bpm_pkg::CNT_W + 1)'(bpm_pkg::MAX_ENTRIES)) begin
            err_d          = 1'b1;
            s1_valid_d     = 1'b1;
            s1_desc_d.kind = bpm_pkg::KIND_TABLE_FULL;
          end else begin
            // Pop: the open position arrives from the RAM next cycle.
            top_d           = top_q - bpm_pkg::TOP_W'(1);
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = top_d[bpm_pkg::ADDR_W-1:0];
            cnt_d           = cnt_plus2[bpm_pkg::CNT_W-1:0];
            s1_valid_d      = 1'b1;
            s1_desc_d.kind  = bpm_pkg::KIND_ENTRY;
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      err_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      top_q      <= top_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      err_q      <= err_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Result record.
  always_ff @(posedge clk_i) begin
    s1_desc_q <= s1_desc_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_desc_o  = s1_desc_q;

  // The stack pointer never passes the stack depth.
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= bpm_pkg::TOP_W'(bpm_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // Entries come in pairs and never exceed the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cnt_q[0] && (cnt_q <= bpm_pkg::CNT_W'(bpm_pkg::MAX_ENTRIES)))
    else $error("entry count odd or beyond table size");

  // One character either pushes or pops, never both.
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("stack RAM read and write in the same cycle");

  // An end transfer leaves the block in its reset state.
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.end_of_program |=> (top_q == '0) && (cnt_q == '0) && !err_q
                                    && (pos_q == '0))
    else $error("state not cleared after end of program");

endmodule

/* sv/bpm_out.sv */
// ----------------------------------------------------------------------------
// Bracket pair matcher output stage
// Output register that turns one result record into one or two transfers;
// a matched pair gives the open-to-close entry, then the close-to-open one.
// ----------------------------------------------------------------------------
module bpm_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  input  bpm_pkg::desc_t                s1_desc_i,
  input  logic [bpm_pkg::POS_WIDTH-1:0] rd_data_i,
  output logic                          s1_take_o,
  bpm_out_if.source                     out_o
);

  logic           valid_q;
  logic           pend_q;
  logic           last_q;
  bpm_pkg::kind_e kind_q;
  logic [15:0]    from_q;
  logic [15:0]    to_q;
  logic [14:0]    idx_q;
  logic [15:0]    total_q;
  logic           out_free;
  logic           is_entry;

  // The register can load when empty or when its final transfer completes.
  assign out_free  = !valid_q || (out_o.ready && last_q);
  assign s1_take_o = s1_valid_i && out_free;
  assign is_entry  = (s1_desc_i.kind == bpm_pkg::KIND_ENTRY);

  // Handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
    end else if (s1_take_o) begin
      valid_q <= 1'b1;
      pend_q  <= is_entry;
      last_q  <= !is_entry;
    end else if (valid_q && out_o.ready) begin
      if (pend_q) begin
        pend_q <= 1'b0;
        last_q <= 1'b1;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // Result fields: load a record, or step to the second entry of a pair.
  always_ff @(posedge clk_i) begin
    if (s1_take_o) begin
      kind_q <= s1_desc_i.kind;
      if (is_entry) begin
        from_q  <= 16'(rd_data_i);
        to_q    <= 16'(s1_desc_i.pos);
        idx_q   <= 15'(s1_desc_i.cnt);
        total_q <= 16'(s1_desc_i.cnt + bpm_pkg::CNT_W'(1));
      end else begin
        from_q  <= (s1_desc_i.kind == bpm_pkg::KIND_SUMMARY) ? 16'd0
                                                             : 16'(s1_desc_i.pos);
        to_q    <= 16'd0;
        idx_q   <= 15'd0;
        total_q <= 16'(s1_desc_i.cnt);
      end
    end else if (valid_q && out_o.ready && pend_q) begin
      from_q  <= to_q;
      to_q    <= from_q;
      idx_q   <= idx_q + 15'd1;
      total_q <= total_q + 16'd1;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.from_pos    = from_q;
  assign out_o.to_pos      = to_q;
  assign out_o.entry_index = idx_q;
  assign out_o.entry_total = total_q;
  assign out_o.last        = last_q;

  // A second entry is pending only behind a shown first entry.
  a_pend_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> valid_q && !last_q && (kind_q == bpm_pkg::KIND_ENTRY))
    else $error("pending second entry without a shown first entry");

endmodule

/* sv/bracket_pair_matcher.sv */
// ----------------------------------------------------------------------------
// Bracket pair matcher
// Bracket matching stack that builds a jump table from a stream of program
// characters.
// ----------------------------------------------------------------------------
// The block takes one program character per clock cycle while the output is
// not stalled. An open bracket pushes its position onto a stack held in a
// synchronous RAM; a close bracket pops it and yields two jump table entries,
// open to close and then close to open, which leave as two consecutive output
// transfers. Every other character yields one result at most, so the
// sustained rate is one character per cycle except that each close bracket
// occupies the output for two transfers. The stack RAM read is covered by a
// one-record stage between the control logic and the output register. The
// first error is reported once; later characters produce nothing until the
// end transfer, which always returns a summary and clears all state. No
// clearing pass runs after reset: only pushed stack entries are ever read.
module bracket_pair_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpm_in_if.sink     in_i,
  bpm_out_if.source  out_o
);

  logic                          s1_valid;
  bpm_pkg::desc_t                s1_desc;
  logic                          s1_take;
  bpm_pkg::ram_req_t             ram_req;
  logic [bpm_pkg::POS_WIDTH-1:0] rd_data;

  // Character handling and state.
  bpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .s1_valid_o (s1_valid),
    .s1_desc_o  (s1_desc),
    .s1_take_i  (s1_take),
    .ram_req_o  (ram_req)
  );

  // Open bracket positions.
  bpm_ram #(
    .DATA_W (bpm_pkg::POS_WIDTH),
    .DEPTH  (bpm_pkg::STACK_DEPTH),
    .ADDR_W (bpm_pkg::ADDR_W)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rd_data)
  );

  // Result formatting and output register.
  bpm_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_desc_i  (s1_desc),
    .rd_data_i  (rd_data),
    .s1_take_o  (s1_take),
    .out_o      (out_o)
  );

endmodule

/* bench/bpm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bracket pair matcher checker
// Watches the character and result channels, predicts the jump table results
// of every accepted character and compares each accepted result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bpm_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bpm_in_if    char_i,
  bpm_out_if   jump_i,
  output int   fail_count_o,
  output int   pending_o
);

  // One result as it leaves the block.
  typedef struct packed {
    bpm_pkg::kind_e kind;
    logic [15:0]    from_pos;
    logic [15:0]    to_pos;
    logic [14:0]    entry_index;
    logic [15:0]    entry_total;
    logic           last;
  } jump_result_t;

  // Results predicted but not yet seen, oldest first.
  jump_result_t jump_results_due[$];

  // Predicted state of the matcher.
  logic [bpm_pkg::POS_WIDTH-1:0] open_positions [bpm_pkg::STACK_DEPTH];
  int unsigned                   open_count;
  logic [bpm_pkg::POS_W-1:0]     next_char_pos;
  int unsigned                   table_entries;
  logic                          error_latched;

  jump_result_t seen_result;
  int           fail_count = 0;
  int           pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic jump_result_t make_result(input bpm_pkg::kind_e k,
                                               input int unsigned from_v,
                                               input int unsigned to_v,
                                               input int unsigned idx_v,
                                               input int unsigned total_v, input logic last_v);
    jump_result_t r;
    r.kind        = k;
    r.from_pos    = from_v[15:0];
    r.to_pos      = to_v[15:0];
    r.entry_index = idx_v[14:0];
    r.entry_total = total_v[15:0];
    r.last        = last_v;
    return r;
  endfunction

  function automatic void clear_matcher();
    open_count    = 0;
    next_char_pos = '0;
    table_entries = 0;
    error_latched = 1'b0;
  endfunction

  // Raise the sticky error and predict its single result.
  function automatic void raise_error(input bpm_pkg::kind_e k,
                                      input logic [bpm_pkg::POS_W-1:0] pos);
    error_latched = 1'b1;
    jump_results_due.push_back(make_result(k, 32'(pos), 0, 0, table_entries, 1'b1));
  endfunction

  // Predict the results of one accepted character transfer.
  function automatic void predict_char(input logic [7:0] sym, input logic eop);
    logic [bpm_pkg::POS_W-1:0]     pos;
    logic [bpm_pkg::POS_WIDTH-1:0] open_at;
    if (eop) begin
      // The end transfer always reports the count, then starts a new program.
      jump_results_due.push_back(make_result(bpm_pkg::KIND_SUMMARY, 0, 0, 0, table_entries,
                                             1'b1));
      clear_matcher();
    end else if (!error_latched) begin
      pos = next_char_pos;
      // The position counter stops one past the largest position.
      if (!next_char_pos[bpm_pkg::POS_WIDTH]) begin
        next_char_pos = next_char_pos + bpm_pkg::POS_W'(1);
      end
      if (pos[bpm_pkg::POS_WIDTH]) begin
        raise_error(bpm_pkg::KIND_TOO_LONG, pos);
      end else if (sym == bpm_pkg::SYM_OPEN) begin
        if (open_count >= bpm_pkg::STACK_DEPTH) begin
          raise_error(bpm_pkg::KIND_STACK_OVF, pos);
        end else begin
          open_positions[open_count[bpm_pkg::ADDR_W-1:0]] = pos[bpm_pkg::POS_WIDTH-1:0];
          open_count++;
        end
      end else if (sym == bpm_pkg::SYM_CLOSE) begin
        if (open_count == 0) begin
          raise_error(bpm_pkg::KIND_UNMATCHED, pos);
        end else if (table_entries + 2 > bpm_pkg::MAX_ENTRIES) begin
          raise_error(bpm_pkg::KIND_TABLE_FULL, pos);
        end else begin
          // A matched pair writes open to close, then close to open.
          open_count--;
          open_at = open_positions[open_count[bpm_pkg::ADDR_W-1:0]];
          jump_results_due.push_back(make_result(bpm_pkg::KIND_ENTRY, 32'(open_at),
                                                 32'(pos), table_entries,
                                                 table_entries + 1, 1'b0));
          jump_results_due.push_back(make_result(bpm_pkg::KIND_ENTRY, 32'(pos),
                                                 32'(open_at), table_entries + 1,
                                                 table_entries + 2, 1'b1));
          table_entries += 2;
        end
      end
    end
  endfunction

  function automatic string field_text(input string name, input int unsigned got,
                                       input int unsigned want);
    return $sformatf("%s is %0d, expected %0d", name, got, want);
  endfunction

  // Compare one accepted result with the oldest prediction.
  task automatic check_result(input jump_result_t got);
    jump_result_t want;
    if (jump_results_due.size() == 0) begin
      report_mismatch($sformatf("result of kind %0d from %0d with none pending",
                                got.kind, got.from_pos));
    end else begin
      want = jump_results_due.pop_front();
      if (got.kind != want.kind) begin
        report_mismatch(field_text("kind", 32'(got.kind), 32'(want.kind)));
      end
      if (got.from_pos != want.from_pos) begin
        report_mismatch(field_text("from_pos", 32'(got.from_pos), 32'(want.from_pos)));
      end
      if (got.to_pos != want.to_pos) begin
        report_mismatch(field_text("to_pos", 32'(got.to_pos), 32'(want.to_pos)));
      end
      if (got.entry_index != want.entry_index) begin
        report_mismatch(field_text("entry_index", 32'(got.entry_index),
                                   32'(want.entry_index)));
      end
      if (got.entry_total != want.entry_total) begin
        report_mismatch(field_text("entry_total", 32'(got.entry_total),
                                   32'(want.entry_total)));
      end
      if (got.last != want.last) begin
        report_mismatch(field_text("last", 32'(got.last), 32'(want.last)));
      end
    end
  endtask

  // Sample both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_matcher();
      jump_results_due.delete();
    end else begin
      if (char_i.valid && char_i.ready) begin
        predict_char(char_i.symbol, char_i.end_of_program);
      end
      if (jump_i.valid && jump_i.ready) begin
        seen_result.kind        = bpm_pkg::kind_e'(jump_i.kind);
        seen_result.from_pos    = jump_i.from_pos;
        seen_result.to_pos      = jump_i.to_pos;
        seen_result.entry_index = jump_i.entry_index;
        seen_result.entry_total = jump_i.entry_total;
        seen_result.last        = jump_i.last;
        check_result(seen_result);
      end
    end
    pending = jump_results_due.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bracket pair matcher testbench
// Drives program characters into the matcher: a short directed program set,
// a program that fills the stack to its depth and overflows it, then random
// programs, mostly well formed. Both channels idle in random bursts. A
// checker beside the block predicts and compares every result; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  // Cycles without any transfer before the run is abandoned.
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned QUIET_ITEMS = 200;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpm_in_if  char_if ();
  bpm_out_if jump_if ();

  int          fail_count;
  int          pending;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned chars_sent = 0;
  int unsigned pace_levels[3] = '{0, 10, 30};

  bracket_pair_matcher u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (jump_if)
  );

  bpm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (char_if),
    .jump_i       (jump_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // Result side back-pressure: random stall bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      jump_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      jump_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      jump_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      jump_if.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (jump_if.valid && jump_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one character, after an optional gap, and wait for its transfer.
  task automatic send_char(input logic [7:0] sym, input logic eop);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.symbol <= sym;
    char_if.end_of_program <= eop;
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
  endtask

  task automatic send_end();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Hold the sender until every predicted result has arrived.
  task automatic drain_results();
    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == bpm_pkg::SYM_OPEN || c == bpm_pkg::SYM_CLOSE) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Random program body of exactly len characters. With balance set, every
  // open bracket is closed within the body; depth_o returns what is left open.
  task automatic send_program(input int unsigned len, input int unsigned bracket_pct,
                              input bit balance, input int unsigned max_depth,
                              output int unsigned depth_o);
    int unsigned depth;
    int unsigned roll;
    depth = 0;
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (balance && len - i <= depth) begin
        send_char(bpm_pkg::SYM_CLOSE, 1'b0);
        depth--;
      end else if (roll < bracket_pct / 2 && depth < max_depth &&
                   (!balance || len - i > depth + 1)) begin
        send_char(bpm_pkg::SYM_OPEN, 1'b0);
        depth++;
      end else if (roll < bracket_pct && depth > 0) begin
        send_char(bpm_pkg::SYM_CLOSE, 1'b0);
        depth--;
      end else begin
        send_char(plain_char(), 1'b0);
      end
    end
    depth_o = depth;
  endtask

  task automatic set_pacing(input int unsigned gap, input int unsigned stall);
    gap_pct = gap;
    stall_pct = stall;
  endtask

  initial begin
    int unsigned left_open;
    int unsigned rand_goal;
    int unsigned len;
    int unsigned style;
    char_if.valid = 1'b0;
    char_if.symbol = 8'h00;
    char_if.end_of_program = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty program.
    send_end();
    // Matched and nested pairs among the lowest and highest plain bytes; the
    // end transfer carries an open bracket that must be ignored.
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(bpm_pkg::SYM_OPEN, 1'b1);
    // Unmatched close first; the characters after it are silent.
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_end();
    // Open brackets left at the end are fine; neighbors of the bracket codes.
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(8'h5A, 1'b0);
    send_char(8'h5C, 1'b0);
    send_end();
    // Unmatched close after entries were written.
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(8'h5E, 1'b0);
    send_end();
    drain_results();

    // Stack filled to its depth, a pop from the full stack, refilled, then
    // the open bracket past the depth is the stack overflow.
    set_pacing(5, 5);
    repeat (bpm_pkg::STACK_DEPTH) send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(bpm_pkg::SYM_OPEN, 1'b0);
    send_char(bpm_pkg::SYM_CLOSE, 1'b0);
    send_char(plain_char(), 1'b0);
    send_end();
    drain_results();

    // Random programs, mostly well formed, with changing pacing.
    rand_goal = chars_sent + RANDOM_ITEMS;
    while (chars_sent < rand_goal) begin
      if (chars_sent + QUIET_ITEMS >= rand_goal) begin
        set_pacing(0, 0);
      end else if ($urandom_range(0, 3) == 0) begin
        set_pacing(pace_levels[$urandom_range(0, 2)], pace_levels[$urandom_range(0, 2)]);
      end
      style = $urandom_range(0, 9);
      len = $urandom_range(0, 40);
      if (style <= 6) begin
        send_program(len, 50, 1'b1, 16, left_open);
      end else if (style == 7) begin
        // Noise: brackets and bytes in any order.
        repeat (len) begin
          case ($urandom_range(0, 2))
            0: send_char(bpm_pkg::SYM_OPEN, 1'b0);
            1: send_char(bpm_pkg::SYM_CLOSE, 1'b0);
            default: send_char(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end
      end else if (style == 8) begin
        // Broken: one close more than there are opens, then trailing bytes.
        send_program(len, 50, 1'b0, 16, left_open);
        repeat (left_open + 1) send_char(bpm_pkg::SYM_CLOSE, 1'b0);
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_program(len, 60, 1'b0, 16, left_open);
      end
      send_end();
      if ($urandom_range(0, 15) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
